/* sv/ssdm_pkg.sv */
// ----------------------------------------------------------------------------
// Stick smooth/deadband map package
// Shared widths, register map, reset values and interface structs.
// ----------------------------------------------------------------------------
package ssdm_pkg;

    localparam int DEF_NUM_AXES    = 4;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam int CAL_BITS      = 12;
    localparam int SHIFT_BITS    = 4;
    localparam int OUT_BITS      = 11;
    localparam int REG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam int GMAG_BITS = OUT_BITS;
    localparam int QUOT_BITS = OUT_BITS;
    localparam int PROD_BITS = GMAG_BITS + CAL_BITS;

    localparam logic [CAL_BITS-1:0]   RST_CAL_MIN      = 12'd100;
    localparam logic [CAL_BITS-1:0]   RST_CAL_CENTER   = 12'd2048;
    localparam logic [CAL_BITS-1:0]   RST_CAL_MAX      = 12'd3995;
    localparam logic [CAL_BITS-1:0]   RST_DEAD_BAND    = 12'd20;
    localparam logic [SHIFT_BITS-1:0] RST_SMOOTH_SHIFT = 4'd2;
    localparam logic [OUT_BITS-1:0]   RST_OUT_LOW      = 11'd172;
    localparam logic [OUT_BITS-1:0]   RST_OUT_MID      = 11'd992;
    localparam logic [OUT_BITS-1:0]   RST_OUT_HIGH     = 11'd1811;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CAL_MIN      = 3'd0,
        REG_CAL_CENTER   = 3'd1,
        REG_CAL_MAX      = 3'd2,
        REG_DEAD_BAND    = 3'd3,
        REG_SMOOTH_SHIFT = 3'd4,
        REG_OUT_LOW      = 3'd5,
        REG_OUT_MID      = 3'd6,
        REG_OUT_HIGH     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CAL_BITS-1:0]   cal_min;
        logic [CAL_BITS-1:0]   cal_center;
        logic [CAL_BITS-1:0]   cal_max;
        logic [CAL_BITS-1:0]   dead_band;
        logic [SHIFT_BITS-1:0] smooth_shift;
        logic [OUT_BITS-1:0]   out_low;
        logic [OUT_BITS-1:0]   out_mid;
        logic [OUT_BITS-1:0]   out_high;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [GMAG_BITS-1:0] gain;
        logic [CAL_BITS-1:0]  delta;
        logic [CAL_BITS-1:0]  span;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [QUOT_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

/* sv/ssdm_in_if.sv */
// ----------------------------------------------------------------------------
// Stick smooth/deadband map input channel
// One request carries one raw sample per axis.
// ----------------------------------------------------------------------------
interface ssdm_in_if
    import ssdm_pkg::*;
#(
    parameter int NUM_AXES    = DEF_NUM_AXES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                                   valid;
    logic                                   ready;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* sv/ssdm_out_if.sv */
// ----------------------------------------------------------------------------
// Stick smooth/deadband map output channel
// One request carries one mapped channel value per axis.
// ----------------------------------------------------------------------------
interface ssdm_out_if
    import ssdm_pkg::*;
#(
    parameter int NUM_AXES = DEF_NUM_AXES
) ();
    logic                                valid;
    logic                                ready;
    logic [NUM_AXES-1:0][OUT_BITS-1:0]   channel;

    modport source (output valid, output channel, input ready);
    modport sink   (input valid, input channel, output ready);
endinterface

/* sv/ssdm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Stick smooth/deadband map configuration registers
// Write-only calibration and output range register file.
// ----------------------------------------------------------------------------
module ssdm_cfg_regs
    import ssdm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_min      <= RST_CAL_MIN;
            cfg_reg.cal_center   <= RST_CAL_CENTER;
            cfg_reg.cal_max      <= RST_CAL_MAX;
            cfg_reg.dead_band    <= RST_DEAD_BAND;
            cfg_reg.smooth_shift <= RST_SMOOTH_SHIFT;
            cfg_reg.out_low      <= RST_OUT_LOW;
            cfg_reg.out_mid      <= RST_OUT_MID;
            cfg_reg.out_high     <= RST_OUT_HIGH;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CAL_MIN:      cfg_reg.cal_min      <= cfg_data[CAL_BITS-1:0];
                REG_CAL_CENTER:   cfg_reg.cal_center   <= cfg_data[CAL_BITS-1:0];
                REG_CAL_MAX:      cfg_reg.cal_max      <= cfg_data[CAL_BITS-1:0];
                REG_DEAD_BAND:    cfg_reg.dead_band    <= cfg_data[CAL_BITS-1:0];
                REG_SMOOTH_SHIFT: cfg_reg.smooth_shift <= cfg_data[SHIFT_BITS-1:0];
                REG_OUT_LOW:      cfg_reg.out_low      <= cfg_data[OUT_BITS-1:0];
                REG_OUT_MID:      cfg_reg.out_mid      <= cfg_data[OUT_BITS-1:0];
                REG_OUT_HIGH:     cfg_reg.out_high     <= cfg_data[OUT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/ssdm_div.sv */
// ----------------------------------------------------------------------------
// Stick smooth/deadband map scaling divider
// Multiplies gain by distance, then divides by span one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ssdm_div
    import ssdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(QUOT_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CAL_BITS-1:0]  rem_reg;
    logic [QUOT_BITS-1:0] num_reg;
    logic [CAL_BITS-1:0]  span_reg;

    logic [PROD_BITS-1:0] prod;
    logic [CAL_BITS:0]    trial;
    logic                 fits;

    assign prod  = PROD_BITS'(req.gain) * PROD_BITS'(req.delta);
    assign trial = {rem_reg, num_reg[QUOT_BITS-1]};
    assign fits  = trial >= {1'b0, span_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QUOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= prod[PROD_BITS-1:QUOT_BITS];
            num_reg  <= prod[QUOT_BITS-1:0];
            span_reg <= req.span;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CAL_BITS'(trial - {1'b0, span_reg}) : trial[CAL_BITS-1:0];
            num_reg <= {num_reg[QUOT_BITS-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

/* sv/stick_smooth_deadband_map.sv */
// ----------------------------------------------------------------------------
// Stick smooth/deadband map
// Smooths joystick axis samples and maps them through deadband and calibration.
// ----------------------------------------------------------------------------
// One frame is taken at a time and axes are worked one after another. Per axis
// the sequencer runs the smoothing step and then the deadband and calibration
// checks; an axis outside the deadband with a positive span on its side then
// passes through a start state, the shared 11-step divider and a final state
// that scales and clamps. An axis in the deadband or on a side of zero or
// negative span gets out_mid directly. The next frame is taken in the cycle
// after the result is loaded into the output register, even if that result
// has not yet been taken.
module stick_smooth_deadband_map
    import ssdm_pkg::*;
#(
    parameter int NUM_AXES    = DEF_NUM_AXES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    ssdm_in_if.sink                  frame,
    ssdm_out_if.source               result,
    input  logic                     cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int VW  = ((SAMPLE_BITS > CAL_BITS) ? SAMPLE_BITS : CAL_BITS) + 2;
    localparam int RW  = OUT_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SMOOTH,
        S_CLASS,
        S_START,
        S_DIV,
        S_FIN,
        S_DONE
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t                               state_reg;
    logic [AXW-1:0]                       axis_reg;
    logic                                 primed_reg;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] samp_reg;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] smooth_reg;
    logic [NUM_AXES-1:0][OUT_BITS-1:0]    chan_reg;
    logic [NUM_AXES-1:0][OUT_BITS-1:0]    out_chan_reg;
    logic                                 out_valid_reg;
    logic [GMAG_BITS-1:0]                 gain_reg;
    logic                                 gneg_reg;
    logic [CAL_BITS-1:0]                  dist_reg;
    logic [CAL_BITS-1:0]                  span_reg;

    logic                                 last_axis;
    logic                                 out_free;
    logic                                 out_load;

    logic signed [SAMPLE_BITS:0]          diff;
    logic signed [SAMPLE_BITS:0]          step;
    logic [SAMPLE_BITS-1:0]               smooth_next;

    logic signed [VW-1:0]                 v_s;
    logic signed [VW-1:0]                 ctr_s;
    logic signed [VW-1:0]                 cmin_s;
    logic signed [VW-1:0]                 cmax_s;
    logic signed [VW-1:0]                 db_s;
    logic signed [VW-1:0]                 span_s;
    logic signed [VW-1:0]                 dist_s;
    logic                                 in_band;
    logic                                 lower;
    logic                                 direct;
    logic signed [OUT_BITS:0]             gain_s;

    logic signed [RW-1:0]                 mid_s;
    logic signed [RW-1:0]                 lo_s;
    logic signed [RW-1:0]                 hi_s;
    logic signed [RW-1:0]                 quot_s;
    logic signed [RW-1:0]                 res_raw;
    logic signed [RW-1:0]                 res_lo;
    logic signed [RW-1:0]                 res_fin;

    ssdm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssdm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign last_axis = (axis_reg == AXW'(NUM_AXES - 1));
    assign out_free  = !out_valid_reg || result.ready;
    assign out_load  = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        diff        = $signed({1'b0, samp_reg[axis_reg]}) - $signed({1'b0, smooth_reg[axis_reg]});
        step        = diff >>> cfg.smooth_shift;
        smooth_next = primed_reg ? SAMPLE_BITS'(smooth_reg[axis_reg] + step[SAMPLE_BITS-1:0])
                                 : samp_reg[axis_reg];
    end

    always_comb
    begin
        v_s    = VW'(smooth_reg[axis_reg]);
        ctr_s  = VW'(cfg.cal_center);
        cmin_s = VW'(cfg.cal_min);
        cmax_s = VW'(cfg.cal_max);
        db_s   = VW'(cfg.dead_band);
        in_band = (v_s > ctr_s - db_s) && (v_s < ctr_s + db_s);
        lower   = (v_s <= ctr_s);
        if (lower)
        begin
            span_s = ctr_s - cmin_s;
            dist_s = ctr_s - ((v_s < cmin_s) ? cmin_s : v_s);
            gain_s = $signed({1'b0, cfg.out_low}) - $signed({1'b0, cfg.out_mid});
        end
        else
        begin
            span_s = cmax_s - ctr_s;
            dist_s = ((v_s > cmax_s) ? cmax_s : v_s) - ctr_s;
            gain_s = $signed({1'b0, cfg.out_high}) - $signed({1'b0, cfg.out_mid});
        end
        direct = in_band || (span_s <= 0);
    end

    always_comb
    begin
        mid_s   = RW'(cfg.out_mid);
        lo_s    = RW'(cfg.out_low);
        hi_s    = RW'(cfg.out_high);
        quot_s  = RW'(div_rsp.quotient);
        res_raw = gneg_reg ? (mid_s - quot_s) : (mid_s + quot_s);
        res_lo  = (res_raw < lo_s) ? lo_s : res_raw;
        res_fin = (res_lo > hi_s) ? hi_s : res_lo;
    end

    assign div_req.start = (state_reg == S_START);
    assign div_req.gain  = gain_reg;
    assign div_req.delta = dist_reg;
    assign div_req.span  = span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            samp_reg      <= '0;
            smooth_reg    <= '0;
            chan_reg      <= '0;
            out_chan_reg  <= '0;
            gain_reg      <= '0;
            gneg_reg      <= 1'b0;
            dist_reg      <= '0;
            span_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (frame.valid)
                    begin
                        samp_reg  <= frame.sample;
                        axis_reg  <= '0;
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SMOOTH:
                begin
                    smooth_reg[axis_reg] <= smooth_next;
                    state_reg            <= S_CLASS;
                end
                S_CLASS:
                begin
                    gain_reg <= GMAG_BITS'((gain_s < 0) ? -gain_s : gain_s);
                    gneg_reg <= (gain_s < 0);
                    dist_reg <= CAL_BITS'(dist_s);
                    span_reg <= CAL_BITS'(span_s);
                    if (direct)
                    begin
                        chan_reg[axis_reg] <= cfg.out_mid;
                        if (last_axis)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_SMOOTH;
                        end
                    end
                    else
                    begin
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    chan_reg[axis_reg] <= res_fin[OUT_BITS-1:0];
                    if (last_axis)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_SMOOTH;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_chan_reg <= chan_reg;
                        primed_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign frame.ready    = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.channel = out_chan_reg;

`ifndef ASSERT_OFF
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready) |=> !frame.ready)
        else $error("frame taken while another is in work");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_primed: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(primed_reg))
        else $error("smoothing state lost its primed mark");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stick smooth/deadband map testbench
// Drives frames of raw axis samples and register writes into the block, and
// predicts the smoothed, deadbanded and calibrated channel values of every
// accepted request. Directed frames cover the field extremes, the deadband
// edges, zero and negative spans, crossed output limits and large shifts;
// random phases follow with random register settings, bursty frame traffic
// and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
    import ssdm_pkg::*;

    localparam int NUM_AXES       = DEF_NUM_AXES;
    localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
    localparam int RANDOM_FRAMES  = 1300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 100;

    typedef logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] sample_vec_t;
    typedef logic [NUM_AXES-1:0][OUT_BITS-1:0]    chan_vec_t;

    class stick_scoreboard;
        cfg_t                   cfg;
        logic [SAMPLE_BITS-1:0] smoothed [NUM_AXES];
        bit                     primed;
        chan_vec_t              expected_channels [$];
        int                     errors;
        int                     checked;

        function new();
            cfg.cal_min      = RST_CAL_MIN;
            cfg.cal_center   = RST_CAL_CENTER;
            cfg.cal_max      = RST_CAL_MAX;
            cfg.dead_band    = RST_DEAD_BAND;
            cfg.smooth_shift = RST_SMOOTH_SHIFT;
            cfg.out_low      = RST_OUT_LOW;
            cfg.out_mid      = RST_OUT_MID;
            cfg.out_high     = RST_OUT_HIGH;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                smoothed[a] = '0;
            end
            primed  = 1'b0;
            errors  = 0;
            checked = 0;
        endfunction

        function void report(string msg);
            if (errors < MAX_REPORTS)
            begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endfunction

        function int pending();
            return expected_channels.size();
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_CAL_MIN:      cfg.cal_min      = data[CAL_BITS-1:0];
                REG_CAL_CENTER:   cfg.cal_center   = data[CAL_BITS-1:0];
                REG_CAL_MAX:      cfg.cal_max      = data[CAL_BITS-1:0];
                REG_DEAD_BAND:    cfg.dead_band    = data[CAL_BITS-1:0];
                REG_SMOOTH_SHIFT: cfg.smooth_shift = data[SHIFT_BITS-1:0];
                REG_OUT_LOW:      cfg.out_low      = data[OUT_BITS-1:0];
                REG_OUT_MID:      cfg.out_mid      = data[OUT_BITS-1:0];
                REG_OUT_HIGH:     cfg.out_high     = data[OUT_BITS-1:0];
                default:          ;
            endcase
        endfunction

        function logic [OUT_BITS-1:0] map_to_channel(logic [SAMPLE_BITS-1:0] raw);
            int v;
            int cmin;
            int ctr;
            int cmax;
            int db;
            int lo;
            int mid;
            int hi;
            int span;
            int res;
            v    = int'(raw);
            cmin = int'(cfg.cal_min);
            ctr  = int'(cfg.cal_center);
            cmax = int'(cfg.cal_max);
            db   = int'(cfg.dead_band);
            lo   = int'(cfg.out_low);
            mid  = int'(cfg.out_mid);
            hi   = int'(cfg.out_high);
            if (v > ctr - db && v < ctr + db)
            begin
                return cfg.out_mid;
            end
            if (v <= ctr)
            begin
                span = ctr - cmin;
                if (span <= 0)
                begin
                    return cfg.out_mid;
                end
                if (v < cmin)
                begin
                    v = cmin;
                end
                res = mid - ((mid - lo) * (ctr - v)) / span;
            end
            else
            begin
                span = cmax - ctr;
                if (span <= 0)
                begin
                    return cfg.out_mid;
                end
                if (v > cmax)
                begin
                    v = cmax;
                end
                res = mid + ((hi - mid) * (v - ctr)) / span;
            end
            if (res < lo)
            begin
                res = lo;
            end
            if (res > hi)
            begin
                res = hi;
            end
            return res[OUT_BITS-1:0];
        endfunction

        function void take_frame(sample_vec_t s);
            chan_vec_t want;
            int        y;
            int        step;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (!primed)
                begin
                    smoothed[a] = s[a];
                end
                else
                begin
                    y           = int'(smoothed[a]);
                    step        = (int'(s[a]) - y) >>> cfg.smooth_shift;
                    y           = y + step;
                    smoothed[a] = y[SAMPLE_BITS-1:0];
                end
            end
            primed = 1'b1;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                want[a] = map_to_channel(smoothed[a]);
            end
            expected_channels.push_back(want);
        endfunction

        function void check_channels(chan_vec_t got);
            chan_vec_t want;
            if (expected_channels.size() == 0)
            begin
                report($sformatf("result %h with no frame pending", got));
                return;
            end
            want = expected_channels.pop_front();
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (got[a] !== want[a])
                begin
                    report($sformatf("result %0d channel_%0d: got %0d, want %0d",
                                     checked, a, got[a], want[a]));
                end
            end
            checked++;
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [REG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     take_result = 1'b0;

    stick_scoreboard sb;
    cfg_t            cur_cfg;
    int              frames_sent = 0;
    int              burst_left  = 0;
    bit              gaps_on     = 1'b1;
    int              stall_pct   = 0;
    int              stall_left  = 0;
    int              quiet_cycles = 0;
    int              wander_pos [NUM_AXES];

    ssdm_in_if #(.NUM_AXES(NUM_AXES), .SAMPLE_BITS(SAMPLE_BITS)) frame_if ();
    ssdm_out_if #(.NUM_AXES(NUM_AXES)) result_if ();

    assign result_if.ready = take_result;

    stick_smooth_deadband_map #(
        .NUM_AXES    (NUM_AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 25;
                3:       stall_pct <= 60;
                default: stall_pct <= 85;
            endcase
            stall_left <= $urandom_range(100, 900);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        take_result <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            sb.check_channels(result_if.channel);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (frame_if.valid && frame_if.ready) ||
            (result_if.valid && result_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > (1 << SAMPLE_BITS) - 1)
        begin
            return '1;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic sample_vec_t frame4(int a0, int a1, int a2, int a3);
        sample_vec_t s;
        s[0] = clip_sample(a0);
        s[1] = clip_sample(a1);
        s[2] = clip_sample(a2);
        s[3] = clip_sample(a3);
        return s;
    endfunction

    function automatic cfg_t make_cfg(int cmin, int ctr, int cmax, int db, int sh,
                                      int lo, int mid, int hi);
        cfg_t c;
        c.cal_min      = CAL_BITS'(cmin);
        c.cal_center   = CAL_BITS'(ctr);
        c.cal_max      = CAL_BITS'(cmax);
        c.dead_band    = CAL_BITS'(db);
        c.smooth_shift = SHIFT_BITS'(sh);
        c.out_low      = OUT_BITS'(lo);
        c.out_mid      = OUT_BITS'(mid);
        c.out_high     = OUT_BITS'(hi);
        return c;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        int   mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            c = make_cfg($urandom_range(0, 800), $urandom_range(1500, 2600),
                         $urandom_range(3000, 4095), $urandom_range(0, 150),
                         $urandom_range(0, 11), $urandom_range(0, 400),
                         $urandom_range(700, 1300), $urandom_range(1500, 2047));
        end
        else if (mode < 8)
        begin
            c = make_cfg($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            c.cal_min      = $urandom_range(0, 1) ? '1 : '0;
            c.cal_center   = $urandom_range(0, 1) ? '1 : '0;
            c.cal_max      = $urandom_range(0, 1) ? '1 : '0;
            c.dead_band    = $urandom_range(0, 1) ? '1 : '0;
            c.smooth_shift = $urandom_range(0, 1) ? '1 : '0;
            c.out_low      = $urandom_range(0, 1) ? '1 : '0;
            c.out_mid      = $urandom_range(0, 1) ? '1 : '0;
            c.out_high     = $urandom_range(0, 1) ? '1 : '0;
        end
        return c;
    endfunction

    function automatic sample_vec_t random_frame(int style);
        sample_vec_t s;
        int          p;
        int          ctr;
        int          db;
        ctr = int'(cur_cfg.cal_center);
        db  = int'(cur_cfg.dead_band);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (style == 0 || $urandom_range(0, 9) == 0)
            begin
                s[a] = SAMPLE_BITS'($urandom);
            end
            else if (style == 1)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    wander_pos[a] = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
                end
                else
                begin
                    wander_pos[a] = int'(clip_sample(wander_pos[a] +
                                                     $urandom_range(0, 64) - 32));
                end
                s[a] = clip_sample(wander_pos[a]);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       p = int'(cur_cfg.cal_min);
                    1:       p = ctr - db;
                    2:       p = ctr + db;
                    3:       p = int'(cur_cfg.cal_max);
                    4:       p = ctr;
                    default: p = $urandom_range(0, 1) ? (1 << SAMPLE_BITS) - 1 : 0;
                endcase
                s[a] = clip_sample(p + $urandom_range(0, 6) - 3);
            end
        end
        return s;
    endfunction

    task automatic send_frame(input sample_vec_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 80) : 0;
            if (gap > 0)
            begin
                frame_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        frame_if.valid  <= 1'b1;
        frame_if.sample <= s;
        do
            @(posedge clk);
        while (!frame_if.ready);
        sb.take_frame(s);
        frames_sent++;
        burst_left--;
    endtask

    task automatic settle();
        frame_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_config(input cfg_t c);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = CFG_DATA_BITS'($urandom);
        write_reg(REG_CAL_MIN, c.cal_min);
        write_reg(REG_CAL_CENTER, c.cal_center);
        write_reg(REG_CAL_MAX, c.cal_max);
        write_reg(REG_DEAD_BAND, c.dead_band);
        write_reg(REG_SMOOTH_SHIFT, {junk[CFG_DATA_BITS-1:SHIFT_BITS], c.smooth_shift});
        write_reg(REG_OUT_LOW, {junk[0], c.out_low});
        write_reg(REG_OUT_MID, {junk[1], c.out_mid});
        write_reg(REG_OUT_HIGH, {junk[2], c.out_high});
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    initial
    begin
        int start_count;
        int style;
        int n;
        sb = new();
        cur_cfg = sb.cfg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            wander_pos[a] = 2048;
        end
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_CAL_MIN;
        cfg_data        <= '0;
        frame_if.valid  <= 1'b0;
        frame_if.sample <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first frame loads directly, then smooth with the reset shift
        gaps_on = 1'b0;
        send_frame(frame4(0, 4095, 2048, 2068));
        send_frame(frame4(4095, 0, 2028, 2029));
        send_frame(frame4(100, 3995, 2067, 2047));

        // track input directly: clamps and deadband edges
        settle();
        write_config(make_cfg(100, 2048, 3995, 20, 0, 172, 992, 1811));
        send_frame(frame4(0, 99, 100, 101));
        send_frame(frame4(2028, 2029, 2067, 2068));
        send_frame(frame4(2048, 2047, 2049, 3994));
        send_frame(frame4(3995, 3996, 4095, 1000));

        // zero span below center, negative span above
        settle();
        write_config(make_cfg(2048, 2048, 1000, 0, 0, 172, 992, 1811));
        send_frame(frame4(0, 4095, 2048, 1));

        // crossed output limits
        settle();
        write_config(make_cfg(100, 2048, 3995, 0, 0, 1500, 200, 1000));
        send_frame(frame4(0, 4095, 1000, 3000));
        send_frame(frame4(100, 3995, 2048, 2047));

        // huge deadband and the largest shift
        settle();
        write_config(make_cfg(0, 4095, 4095, 4095, 15, 0, 2047, 2047));
        send_frame(frame4(0, 0, 0, 0));
        send_frame(frame4(4095, 4095, 4095, 4095));

        // center at zero, no deadband
        settle();
        write_config(make_cfg(0, 0, 4095, 0, 11, 0, 0, 2047));
        send_frame(frame4(4095, 4095, 0, 2048));
        send_frame(frame4(0, 1, 4094, 4095));

        start_count = frames_sent;
        while (frames_sent - start_count < RANDOM_FRAMES)
        begin
            settle();
            write_config(random_config());
            style   = $urandom_range(0, 3);
            style   = (style == 3) ? 1 : style;
            gaps_on = ($urandom_range(0, 2) != 0);
            n       = $urandom_range(10, 60);
            repeat (n) send_frame(random_frame(style));
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
